// ----- src/rhsm_pkg.sv -----
// ============================================================================
// rhsm_pkg: shared types and constants of the rolling hash substring matcher
// Request and result payloads, register indexes, datapath opcodes and the
// command and status bundles between controller and datapath.
// ============================================================================
`default_nettype none

package rhsm_pkg;

  localparam int BYTE_W     = 8;
  localparam int PAT_W      = 64;
  localparam int LEN_W      = 4;
  localparam int HASH_W     = 15;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_W      = 64;
  localparam int BIT_IDX_W  = 3;
  localparam int BYTE_IDX_W = 3;

  localparam logic [BIT_IDX_W-1:0] BIT_TOP = 3'd7;

  // Register indexes of the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_PATTERN_BYTES  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PATTERN_LENGTH = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_HASH_MODULUS   = 2'd2;

  // Reset values of the configuration
  localparam logic [LEN_W-1:0]  RESET_LENGTH  = 4'd1;
  localparam logic [HASH_W-1:0] RESET_MODULUS = 15'd101;
  // Leading weight 256^len mod q for the reset length and modulus (256 mod 101)
  localparam logic [HASH_W-1:0] RESET_WEIGHT  = 15'd54;

  typedef struct packed {
    logic [BYTE_W-1:0] text_byte;
    logic              first_byte;
    logic              last_byte;
  } text_item_t;

  typedef struct packed {
    logic window_match;
    logic found;
    logic end_of_text;
  } result_item_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_TEXT_A,
    S_TEXT_B,
    S_FINISH,
    S_LW_INIT,
    S_LW_STEP,
    S_LW_SAVE,
    S_PH_STEP,
    S_PH_SAVE
  } ctrl_state_t;

  typedef enum logic [3:0] {
    OP_IDLE,
    OP_LW_INIT,
    OP_DOUBLE,
    OP_LW_SAVE,
    OP_PH_SHIFT,
    OP_PH_SAVE,
    OP_ACCEPT,
    OP_TEXT_SHIFT,
    OP_LEAD_SUB,
    OP_EMIT
  } dp_op_t;

  typedef struct packed {
    dp_op_t                 op;
    logic [BYTE_IDX_W-1:0]  byte_sel;
    logic [BIT_IDX_W-1:0]   bit_sel;
  } dp_cmd_t;

  typedef struct packed {
    logic             cfg_hit;
    logic             out_free;
    logic [LEN_W-1:0] len;
  } dp_status_t;

endpackage

`default_nettype wire

// ----- src/rhsm_ctrl.sv -----
// ============================================================================
// rhsm_ctrl: sequencer of the rolling hash substring matcher
// Walks the bit steps of hash derivation after a register write and of the
// rolling hash update for each text request, and hands results to the output.
// ============================================================================
`default_nettype none

module rhsm_ctrl (
  input  wire                    clk,
  input  wire                    rst,
  input  wire                    text_valid,
  output logic                   text_ready,
  input  rhsm_pkg::dp_status_t   status,
  output rhsm_pkg::dp_cmd_t      cmd
);
  import rhsm_pkg::*;

  ctrl_state_t            state, state_next;
  logic [BIT_IDX_W-1:0]   bit_idx, bit_idx_next;
  logic [BYTE_IDX_W-1:0]  byte_idx, byte_idx_next;
  logic [LEN_W-1:0]       byte_ext;

  assign byte_ext = {{(LEN_W-BYTE_IDX_W){1'b0}}, byte_idx};

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      bit_idx  <= BIT_TOP;
      byte_idx <= '0;
    end else begin
      state    <= state_next;
      bit_idx  <= bit_idx_next;
      byte_idx <= byte_idx_next;
    end
  end

  always_comb begin
    state_next    = state;
    bit_idx_next  = bit_idx;
    byte_idx_next = byte_idx;
    cmd.op        = OP_IDLE;
    cmd.bit_sel   = bit_idx;
    cmd.byte_sel  = byte_idx;
    text_ready    = 1'b0;

    unique case (state)
      S_IDLE: begin
        text_ready = !status.cfg_hit;
        if (text_valid && !status.cfg_hit) begin
          cmd.op       = OP_ACCEPT;
          bit_idx_next = BIT_TOP;
          state_next   = S_TEXT_A;
        end
      end
      S_TEXT_A: begin
        cmd.op     = OP_TEXT_SHIFT;
        state_next = S_TEXT_B;
      end
      S_TEXT_B: begin
        cmd.op = OP_LEAD_SUB;
        if (bit_idx == '0) begin
          state_next = S_FINISH;
        end else begin
          bit_idx_next = bit_idx - 1'b1;
          state_next   = S_TEXT_A;
        end
      end
      S_FINISH: begin
        if (status.out_free) begin
          cmd.op     = OP_EMIT;
          state_next = S_IDLE;
        end
      end
      // Leading weight is 256^len: each subtract step follows a doubling,
      // so the weight carries the radix factor of the byte shifted in
      S_LW_INIT: begin
        cmd.op        = OP_LW_INIT;
        bit_idx_next  = BIT_TOP;
        byte_idx_next = '0;
        state_next    = S_LW_STEP;
      end
      S_LW_STEP: begin
        cmd.op = OP_DOUBLE;
        if (bit_idx == '0) begin
          bit_idx_next = BIT_TOP;
          if (byte_ext + LEN_W'(1) == status.len) begin
            state_next = S_LW_SAVE;
          end else begin
            byte_idx_next = byte_idx + 1'b1;
          end
        end else begin
          bit_idx_next = bit_idx - 1'b1;
        end
      end
      S_LW_SAVE: begin
        cmd.op        = OP_LW_SAVE;
        bit_idx_next  = BIT_TOP;
        byte_idx_next = '0;
        state_next    = S_PH_STEP;
      end
      S_PH_STEP: begin
        cmd.op = OP_PH_SHIFT;
        if (bit_idx == '0) begin
          bit_idx_next = BIT_TOP;
          if (byte_ext + LEN_W'(1) == status.len) begin
            state_next = S_PH_SAVE;
          end else begin
            byte_idx_next = byte_idx + 1'b1;
          end
        end else begin
          bit_idx_next = bit_idx - 1'b1;
        end
      end
      S_PH_SAVE: begin
        cmd.op     = OP_PH_SAVE;
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase

    // A register write restarts the derivation from any state
    if (status.cfg_hit) begin
      state_next = S_LW_INIT;
    end
  end

endmodule

`default_nettype wire

// ----- src/rhsm_datapath.sv -----
// ============================================================================
// rhsm_datapath: configuration, window and modular hash datapath
// Holds the configuration, the byte window, the rolling hash and the derived
// pattern hash and leading weight; performs one modular step per command.
// ============================================================================
`default_nettype none

module rhsm_datapath #(
  parameter int MAX_PATTERN = 8
) (
  input  wire                          clk,
  input  wire                          rst,
  input  rhsm_pkg::text_item_t         text_item,
  input  wire                          cfg_write,
  input  wire [rhsm_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire [rhsm_pkg::CFG_W-1:0]    cfg_data,
  input  rhsm_pkg::dp_cmd_t            cmd,
  input  wire                          result_ready,
  output logic                         result_valid,
  output rhsm_pkg::result_item_t       result_item,
  output rhsm_pkg::dp_status_t         status
);
  import rhsm_pkg::*;

  localparam int SEEN_W = $clog2(MAX_PATTERN + 1);

  logic [PAT_W-1:0]   pattern_bytes;
  logic [LEN_W-1:0]   pattern_length;
  logic [HASH_W-1:0]  hash_modulus;
  logic [HASH_W-1:0]  leading_weight;
  logic [HASH_W-1:0]  pattern_hash;
  logic [HASH_W-1:0]  rolling_hash;
  logic [BYTE_W-1:0]  window [MAX_PATTERN];
  logic [SEEN_W-1:0]  bytes_seen;
  logic               found_flag;
  logic [BYTE_W-1:0]  new_byte;
  logic [BYTE_W-1:0]  lead_byte;
  logic               sub_en;
  logic               last_flag;

  logic [LEN_W-1:0]   len_eff;
  logic [HASH_W-1:0]  mod_eff;
  logic               window_full;
  logic [BYTE_W-1:0]  lead_sel;
  logic               shift_bit;
  logic [HASH_W:0]    dbl;
  logic [HASH_W-1:0]  dbl_red;
  logic [HASH_W:0]    sub_wrap;
  logic [HASH_W-1:0]  sub_red;
  logic               exact;
  logic               match;

  // Effective length and modulus
  always_comb begin
    if (pattern_length == '0) begin
      len_eff = LEN_W'(1);
    end else if (pattern_length > LEN_W'(MAX_PATTERN)) begin
      len_eff = LEN_W'(MAX_PATTERN);
    end else begin
      len_eff = pattern_length;
    end
  end

  assign mod_eff     = (hash_modulus == '0) ? HASH_W'(1) : hash_modulus;
  assign window_full = LEN_W'(bytes_seen) >= len_eff;

  // Byte that leaves the window on this step
  always_comb begin
    lead_sel = '0;
    for (int j = 0; j < MAX_PATTERN; j++) begin
      if (LEN_W'(j) == len_eff - LEN_W'(1)) begin
        lead_sel = window[j];
      end
    end
  end

  always_comb begin
    unique case (cmd.op)
      OP_PH_SHIFT:   shift_bit = pattern_bytes[{cmd.byte_sel, cmd.bit_sel}];
      OP_TEXT_SHIFT: shift_bit = new_byte[cmd.bit_sel];
      default:       shift_bit = 1'b0;
    endcase
  end

  // hash <- (2*hash + bit) mod q, input below 2q
  assign dbl     = {rolling_hash, shift_bit};
  assign dbl_red = (dbl >= {1'b0, mod_eff}) ? HASH_W'(dbl - {1'b0, mod_eff})
                                            : dbl[HASH_W-1:0];

  // hash <- (hash - weight) mod q
  assign sub_wrap = {1'b0, rolling_hash} + {1'b0, mod_eff} - {1'b0, leading_weight};
  assign sub_red  = (rolling_hash >= leading_weight) ? rolling_hash - leading_weight
                                                     : sub_wrap[HASH_W-1:0];

  // Exact compare: window entry j against pattern byte len-1-j
  always_comb begin
    logic [BYTE_IDX_W-1:0] pat_idx;
    logic [PAT_W-1:0]      pat_shift;
    exact     = 1'b1;
    pat_idx   = '0;
    pat_shift = '0;
    for (int j = 0; j < MAX_PATTERN; j++) begin
      pat_idx   = BYTE_IDX_W'(len_eff - LEN_W'(1) - LEN_W'(j));
      pat_shift = pattern_bytes >> {pat_idx, 3'b000};
      if ((LEN_W'(j) < len_eff) && (window[j] != pat_shift[BYTE_W-1:0])) begin
        exact = 1'b0;
      end
    end
  end

  assign match = window_full && (rolling_hash == pattern_hash) && exact;

  assign status.cfg_hit  = cfg_write && ((cfg_index == REG_PATTERN_BYTES) ||
                                         (cfg_index == REG_PATTERN_LENGTH) ||
                                         (cfg_index == REG_HASH_MODULUS));
  assign status.out_free = !result_valid || result_ready;
  assign status.len      = len_eff;

  // Control and hash state
  always_ff @(posedge clk) begin
    if (rst) begin
      pattern_bytes  <= '0;
      pattern_length <= RESET_LENGTH;
      hash_modulus   <= RESET_MODULUS;
      leading_weight <= RESET_WEIGHT;
      pattern_hash   <= '0;
      rolling_hash   <= '0;
      bytes_seen     <= '0;
      found_flag     <= 1'b0;
      sub_en         <= 1'b0;
      result_valid   <= 1'b0;
    end else begin
      if (cfg_write) begin
        unique case (cfg_index)
          REG_PATTERN_BYTES:  pattern_bytes  <= cfg_data[PAT_W-1:0];
          REG_PATTERN_LENGTH: pattern_length <= cfg_data[LEN_W-1:0];
          REG_HASH_MODULUS:   hash_modulus   <= cfg_data[HASH_W-1:0];
          default: ;
        endcase
      end

      unique case (cmd.op) inside
        OP_LW_INIT: begin
          rolling_hash <= (mod_eff == HASH_W'(1)) ? '0 : HASH_W'(1);
        end
        OP_DOUBLE, OP_PH_SHIFT, OP_TEXT_SHIFT: begin
          rolling_hash <= dbl_red;
        end
        OP_LW_SAVE: begin
          leading_weight <= rolling_hash;
          rolling_hash   <= '0;
        end
        OP_PH_SAVE: begin
          pattern_hash <= rolling_hash;
          rolling_hash <= '0;
          bytes_seen   <= '0;
          found_flag   <= 1'b0;
        end
        OP_ACCEPT: begin
          sub_en <= !text_item.first_byte && window_full;
          if (text_item.first_byte) begin
            rolling_hash <= '0;
            found_flag   <= 1'b0;
            bytes_seen   <= SEEN_W'(1);
          end else if (bytes_seen != SEEN_W'(MAX_PATTERN)) begin
            bytes_seen <= bytes_seen + 1'b1;
          end
        end
        OP_LEAD_SUB: begin
          if (sub_en && lead_byte[cmd.bit_sel]) begin
            rolling_hash <= sub_red;
          end
        end
        OP_EMIT: begin
          found_flag <= found_flag | match;
        end
        default: ;
      endcase

      if (cmd.op == OP_EMIT) begin
        result_valid <= 1'b1;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (cmd.op == OP_ACCEPT) begin
      new_byte  <= text_item.text_byte;
      last_flag <= text_item.last_byte;
      lead_byte <= lead_sel;
      window[0] <= text_item.text_byte;
      for (int j = 1; j < MAX_PATTERN; j++) begin
        window[j] <= window[j-1];
      end
    end
    if (cmd.op == OP_EMIT) begin
      result_item.window_match <= match;
      result_item.found        <= found_flag | match;
      result_item.end_of_text  <= last_flag;
    end
  end

endmodule

`default_nettype wire

// ----- src/rolling_hash_substring_matcher.sv -----
// ============================================================================
// rolling_hash_substring_matcher: Rabin-Karp search over a byte stream
// Rolling hash of the last pattern_length text bytes, radix 256, modulo a
// configured modulus; a hash hit is confirmed by an exact window compare.
// ============================================================================
// One text request is handled at a time by the bit-serial modular unit,
//   which takes two steps (shift-in, leading-byte subtract) per bit; the
//   next request is taken once the result has gone to the output register.
// A register write re-derives the pattern hash and leading weight, with
//   text_ready low meanwhile; the search restarts.
// Reset (rst, synchronous): pattern 0, length 1, modulus 101, search cleared.
`default_nettype none

module rolling_hash_substring_matcher #(
  parameter int MAX_PATTERN = 8
) (
  input  wire                           clk,
  input  wire                           rst,
  input  wire                           text_valid,
  output logic                          text_ready,
  input  rhsm_pkg::text_item_t          text_item,
  output logic                          result_valid,
  input  wire                           result_ready,
  output rhsm_pkg::result_item_t        result_item,
  input  wire                           cfg_write,
  input  wire [rhsm_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire [rhsm_pkg::CFG_W-1:0]     cfg_data
);
  import rhsm_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;

  // Sequencer: accept a request, step the hash bit by bit, hand off result
  rhsm_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .text_valid (text_valid),
    .text_ready (text_ready),
    .status     (status),
    .cmd        (cmd)
  );

  // Datapath: hold configuration, window and hashes; the output register
  // parts the result side, so the next request is taken while one waits
  rhsm_datapath #(
    .MAX_PATTERN (MAX_PATTERN)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .text_item    (text_item),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .cmd          (cmd),
    .result_ready (result_ready),
    .result_valid (result_valid),
    .result_item  (result_item),
    .status       (status)
  );

endmodule

`default_nettype wire

// ----- src/rhsm_checker.sv -----
// ============================================================================
// rhsm_checker: port-level checks of the rolling hash substring matcher
// Watches the request, result and configuration ports over time.
// ============================================================================
`default_nettype none

module rhsm_checker (
  input  wire                           clk,
  input  wire                           rst,
  input  wire                           text_valid,
  input  wire                           text_ready,
  input  rhsm_pkg::text_item_t          text_item,
  input  wire                           result_valid,
  input  wire                           result_ready,
  input  rhsm_pkg::result_item_t        result_item,
  input  wire                           cfg_write,
  input  wire [rhsm_pkg::CFG_IDX_W-1:0] cfg_index
);
  import rhsm_pkg::*;

  // One request at a time: ready drops right after an accept
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    text_valid && text_ready |=> !text_ready)
    else $error("text_ready high right after a request was accepted");

  // A waiting request holds
  a_text_hold: assert property (@(posedge clk) disable iff (rst)
    text_valid && !text_ready |=> text_valid && $stable(text_item))
    else $error("waiting request changed or dropped");

  // A stalled result holds
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> result_valid && $stable(result_item))
    else $error("stalled result changed or dropped");

  // A match always sets the sticky flag in the same result
  a_match_found: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> !result_item.window_match || result_item.found)
    else $error("window_match without found");

  // A register write blocks requests while the hashes are re-derived
  a_cfg_blocks: assert property (@(posedge clk) disable iff (rst)
    cfg_write && ((cfg_index == REG_PATTERN_BYTES) ||
                  (cfg_index == REG_PATTERN_LENGTH) ||
                  (cfg_index == REG_HASH_MODULUS)) |=> !text_ready)
    else $error("text_ready high during derivation");

endmodule

bind rolling_hash_substring_matcher rhsm_checker u_rhsm_checker (.*);

`default_nettype wire

// ----- sim/rolling_hash_substring_matcher_tb.sv -----
// ============================================================================
// rolling_hash_substring_matcher_tb: self-checking bench for the matcher
// Drives text requests through a bursty valid/ready sender. A built-in
// Rabin-Karp predictor computes the expected result of each accepted byte,
// and a monitor compares every returned result field by field, in order.
// ============================================================================
`default_nettype none

module rolling_hash_substring_matcher_tb;
  import rhsm_pkg::*;

  localparam int MAX_PAT = 8;
  localparam int PHASES  = 8;    // random register settings
  localparam int PHASE_N = 65;   // text requests per random setting

  // Index that maps to no register; the block must ignore it
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

  // Directed patterns, first byte in the low byte: "abc" and "ABCDEFGH"
  localparam logic [CFG_W-1:0] PAT_ABC     = 64'h0000_0000_0063_6261;
  localparam logic [CFG_W-1:0] PAT_LETTERS = 64'h4847_4645_4443_4241;

  typedef enum logic [1:0] {RX_OPEN, RX_COIN, RX_SPARSE} rx_mode_t;

  logic                 clk          = 1'b0;
  logic                 rst          = 1'b1;
  logic                 text_valid   = 1'b0;
  logic                 text_ready;
  text_item_t           text_item    = '0;
  logic                 result_valid;
  logic                 result_ready = 1'b0;
  result_item_t         result_item;
  logic                 cfg_write    = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index    = '0;
  logic [CFG_W-1:0]     cfg_data     = '0;

  rolling_hash_substring_matcher #(.MAX_PATTERN(MAX_PAT)) u_top (
    .clk          (clk),
    .rst          (rst),
    .text_valid   (text_valid),
    .text_ready   (text_ready),
    .text_item    (text_item),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result_item  (result_item),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always #4 clk = ~clk;

  // --------------------------------------------------------------------------
  // Search predictor: own copy of the configuration and the search state
  // --------------------------------------------------------------------------
  logic [CFG_W-1:0]  cfg_pat;
  logic [LEN_W-1:0]  cfg_len;
  logic [HASH_W-1:0] cfg_mod;

  logic [7:0]  win_q [MAX_PAT];  // entry 0 holds the newest text byte
  int unsigned roll_h;
  int unsigned pat_h;
  int unsigned lead_w;
  int unsigned seen_cnt;
  logic        found_q;

  text_item_t   pending [$];     // requests waiting for the sender
  result_item_t expected [$];    // results owed by the block, oldest first

  int  mismatch_cnt  = 0;
  int  accepted_cnt  = 0;
  int  results_cnt   = 0;
  int  matches_cnt   = 0;
  int  settings_cnt  = 1;
  bit  hold_send     = 1'b0;
  bit  long_stall_due = 1'b0;

  // Clamp the length register to 1..MAX_PAT
  function automatic int unsigned match_len();
    if (cfg_len == 0) return 1;
    if (cfg_len > MAX_PAT) return MAX_PAT;
    return cfg_len;
  endfunction

  // A zero modulus works as one: every hash collapses to zero
  function automatic int unsigned hash_mod();
    return (cfg_mod == 0) ? 1 : cfg_mod;
  endfunction

  function automatic logic [7:0] pat_at(input int unsigned k);
    return cfg_pat[8*k +: 8];
  endfunction

  function automatic void restart_search();
    foreach (win_q[k]) win_q[k] = '0;
    roll_h   = 0;
    seen_cnt = 0;
    found_q  = 1'b0;
  endfunction

  // Any known register write re-derives the hashes and restarts the search
  function automatic void apply_reg(input logic [CFG_IDX_W-1:0] idx,
                                    input logic [CFG_W-1:0] val);
    int unsigned m, q;
    case (idx)
      REG_PATTERN_BYTES:  cfg_pat = val;
      REG_PATTERN_LENGTH: cfg_len = val[LEN_W-1:0];
      REG_HASH_MODULUS:   cfg_mod = val[HASH_W-1:0];
      default:            return;
    endcase
    m = match_len();
    q = hash_mod();
    lead_w = 1 % q;
    for (int unsigned k = 0; k + 1 < m; k++) lead_w = (lead_w * 256) % q;
    pat_h = 0;
    for (int unsigned k = 0; k < m; k++) pat_h = (pat_h * 256 + pat_at(k)) % q;
    restart_search();
  endfunction

  // Advance the search by one text byte and return the result it causes
  function automatic result_item_t search_step(input text_item_t it);
    int unsigned  m, q, gone;
    logic         hit;
    result_item_t r;
    m = match_len();
    q = hash_mod();
    if (it.first_byte) restart_search();
    roll_h = roll_h % q;
    // drop the byte that leaves the window
    if (seen_cnt >= m) begin
      gone   = (int'(win_q[m-1]) * lead_w) % q;
      roll_h = (roll_h + q - gone) % q;
    end
    roll_h = (roll_h * 256 + it.text_byte) % q;
    for (int k = MAX_PAT - 1; k > 0; k--) win_q[k] = win_q[k-1];
    win_q[0] = it.text_byte;
    if (seen_cnt < MAX_PAT) seen_cnt++;
    // a hash hit only counts once the window bytes equal the pattern
    hit = 1'b0;
    if (seen_cnt >= m && roll_h == pat_h % q) begin
      hit = 1'b1;
      for (int unsigned k = 0; k < m; k++)
        if (win_q[m-1-k] != pat_at(k)) hit = 1'b0;
    end
    if (hit) found_q = 1'b1;
    r.window_match = hit;
    r.found        = found_q;
    r.end_of_text  = it.last_byte;
    return r;
  endfunction

  function automatic void queue_byte(input logic [7:0] b, input logic f, input logic l);
    text_item_t it;
    it.text_byte  = b;
    it.first_byte = f;
    it.last_byte  = l;
    pending.insert(pending.size(), it);
  endfunction

  // Queue a whole text: first flag on its first byte, last flag on its end
  function automatic void queue_string(input string s);
    for (int i = 0; i < s.len(); i++) queue_byte(s[i], i == 0, i == s.len() - 1);
  endfunction

  function automatic void check_field(input string name, input logic want, input logic got);
    if (got !== want) begin
      $error("%s: expected %0b, got %0b", name, want, got);
      mismatch_cnt++;
    end
  endfunction

  // Write one register while the block is idle, then hold until it is ready
  // again (the re-derivation keeps text_ready low for a while)
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    apply_reg(idx, val);
    @(posedge clk);
    cfg_write <= 1'b0;
    repeat (2) @(posedge clk);
    while (!text_ready) @(posedge clk);
  endtask

  // Hold until every queued request went in and every result came back
  task automatic drain();
    while (pending.size() != 0 || text_valid || expected.size() != 0) @(posedge clk);
  endtask

  // --------------------------------------------------------------------------
  // Sender: bursts of requests with random gaps; predict on every accept
  // --------------------------------------------------------------------------
  int burst_left = 1;
  int gap_left   = 0;

  always @(posedge clk) begin : feed_text
    logic offer;
    if (rst) begin
      text_valid <= 1'b0;
    end else begin
      if (text_valid && text_ready) begin
        expected.insert(expected.size(), search_step(text_item));
        accepted_cnt++;
      end
      // keep a request that is still waiting, with its payload untouched
      offer = text_valid && !text_ready;
      if (!offer) begin
        if (gap_left != 0) begin
          gap_left--;
        end else if (!hold_send && pending.size() != 0) begin
          text_item <= pending.pop_front();
          offer = 1'b1;
          burst_left--;
          if (burst_left == 0) begin
            burst_left = $urandom_range(1, 16);
            gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 30);
          end
        end
      end
      text_valid <= offer;
    end
  end

  // --------------------------------------------------------------------------
  // Receiver: stall pattern in segments, plus one long hold-off on request
  // --------------------------------------------------------------------------
  int       stall_left = 0;
  int       seg_left   = 0;
  rx_mode_t rx_mode    = RX_OPEN;

  always @(posedge clk) begin
    if (long_stall_due) begin
      long_stall_due = 1'b0;
      stall_left     = 400;
    end
    if (stall_left != 0) begin
      stall_left--;
      result_ready <= 1'b0;
    end else begin
      if (seg_left == 0) begin
        seg_left = $urandom_range(10, 150);
        rx_mode  = rx_mode_t'($urandom_range(0, 2));
      end
      seg_left--;
      case (rx_mode)
        RX_OPEN:  result_ready <= 1'b1;
        RX_COIN:  result_ready <= 1'($urandom_range(0, 1));
        default:  result_ready <= ($urandom_range(0, 7) == 0);
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: compare each accepted result with the oldest expectation
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : check_result
    result_item_t want;
    if (!rst && result_valid && result_ready) begin
      if (expected.size() == 0) begin
        $error("result with no request outstanding: %b", result_item);
        mismatch_cnt++;
      end else begin
        want = expected.pop_front();
        check_field("window_match", want.window_match, result_item.window_match);
        check_field("found",        want.found,        result_item.found);
        check_field("end_of_text",  want.end_of_text,  result_item.end_of_text);
        results_cnt++;
        if (want.window_match) matches_cnt++;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  initial begin : run_test
    logic [CFG_W-1:0]  pat_v;
    logic [LEN_W-1:0]  len_v;
    logic [HASH_W-1:0] mod_v;
    logic [7:0]        sym_a, sym_b;
    logic [7:0]        txt [$];
    int unsigned       m, tlen, pos;
    int                phase_items, base;
    bit                shaped;

    // predictor starts from the reset configuration
    cfg_pat = '0;
    cfg_len = RESET_LENGTH;
    cfg_mod = RESET_MODULUS;
    pat_h   = 0;
    lead_w  = 1;
    restart_search();

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Reset setting, pattern is a single zero byte. An unknown register
    // index must not restart the search, and a byte after the end of a
    // text without a first flag continues that text.
    queue_byte(8'h00, 1'b1, 1'b0);
    drain();
    write_reg(REG_UNUSED, '1);
    queue_byte(8'hFF, 1'b0, 1'b0);
    queue_byte(8'h00, 1'b0, 1'b1);
    queue_byte(8'h5A, 1'b0, 1'b0);
    queue_byte(8'hA5, 1'b1, 1'b1);
    drain();

    // Three-byte pattern, modulus above the largest prime: a text shorter
    // than the pattern gives no match, then a hit in the middle of a text
    write_reg(REG_PATTERN_BYTES, PAT_ABC);
    write_reg(REG_PATTERN_LENGTH, 64'd3);
    write_reg(REG_HASH_MODULUS, 64'd32767);
    settings_cnt++;
    queue_string("ab");
    queue_string("zabcq");
    drain();

    // Length above the limit clamps to eight; modulus one makes every hash
    // collide, so only the exact compare decides
    write_reg(REG_PATTERN_BYTES, PAT_LETTERS);
    write_reg(REG_PATTERN_LENGTH, 64'd15);
    write_reg(REG_HASH_MODULUS, 64'd1);
    settings_cnt++;
    queue_string("xABCDEFGH");
    drain();

    // Length zero works as one, modulus zero as one, all-ones pattern
    write_reg(REG_PATTERN_BYTES, '1);
    write_reg(REG_PATTERN_LENGTH, 64'd0);
    write_reg(REG_HASH_MODULUS, 64'd0);
    settings_cnt++;
    queue_byte(8'hFF, 1'b1, 1'b0);
    queue_byte(8'h00, 1'b0, 1'b0);
    queue_byte(8'hFF, 1'b0, 1'b1);
    drain();

    // Random settings, each with a batch of texts built mostly from the
    // pattern's own bytes so that hash hits, collisions and overlaps occur
    for (int ph = 0; ph < PHASES; ph++) begin
      pat_v = {$urandom, $urandom};
      if ($urandom_range(0, 2) == 0) begin
        sym_a = 8'($urandom_range(0, 255));
        sym_b = 8'($urandom_range(0, 255));
        for (int k = 0; k < MAX_PAT; k++)
          pat_v[8*k +: 8] = $urandom_range(0, 1) ? sym_a : sym_b;
      end
      len_v = ($urandom_range(0, 9) == 0) ? LEN_W'($urandom_range(0, 15))
                                          : LEN_W'($urandom_range(1, 8));
      case ($urandom_range(0, 7))
        0:       mod_v = 15'd2;
        1:       mod_v = 15'd3;
        2:       mod_v = 15'd32749;
        3:       mod_v = RESET_MODULUS;
        4:       mod_v = HASH_W'($urandom_range(0, 1));
        5:       mod_v = HASH_W'($urandom_range(32750, 32767));
        default: mod_v = HASH_W'($urandom_range(2, 32767));
      endcase
      write_reg(REG_PATTERN_BYTES, pat_v);
      write_reg(REG_PATTERN_LENGTH, CFG_W'(len_v));
      write_reg(REG_HASH_MODULUS, CFG_W'(mod_v));
      if ($urandom_range(0, 2) == 0) write_reg(REG_UNUSED, {$urandom, $urandom});
      settings_cnt++;
      m = match_len();

      phase_items = 0;
      while (phase_items < PHASE_N) begin
        tlen   = $urandom_range(1, 24);
        shaped = ($urandom_range(0, 9) < 7);
        txt.delete();
        for (int unsigned i = 0; i < tlen; i++)
          txt.insert(txt.size(), (shaped && $urandom_range(0, 4) != 0) ?
                     pat_at($urandom_range(0, m - 1)) : 8'($urandom_range(0, 255)));
        // plant a full occurrence in about half of the shaped texts that can hold one
        if (shaped && tlen >= m && $urandom_range(0, 1)) begin
          pos = $urandom_range(0, tlen - m);
          for (int unsigned j = 0; j < m; j++) txt[pos + j] = pat_at(j);
        end
        // mostly well-formed flags; now and then a missing or stray flag
        for (int unsigned i = 0; i < tlen; i++)
          queue_byte(txt[i],
                     (i == 0)        ? ($urandom_range(0, 9) != 0) : ($urandom_range(0, 49) == 0),
                     (i == tlen - 1) ? ($urandom_range(0, 9) != 0) : ($urandom_range(0, 49) == 0));
        phase_items += tlen;
      end

      // hold the receiver off long enough to back up the input side
      if (ph == 2) long_stall_due = 1'b1;
      // pause the sender mid-batch until every owed result has come back
      if (ph == 5) begin
        base = accepted_cnt;
        while (accepted_cnt < base + 30) @(posedge clk);
        hold_send = 1'b1;
        while (text_valid || expected.size() != 0) @(posedge clk);
        hold_send = 1'b0;
      end
      drain();
    end

    // let any stray result surface before the verdict
    repeat (40) @(posedge clk);
    if (expected.size() != 0) begin
      $error("%0d results never arrived", expected.size());
      mismatch_cnt++;
    end

    $display("Checked %0d results for %0d text requests under %0d register settings.",
             results_cnt, accepted_cnt, settings_cnt);
    $display("Window matches seen: %0d; included a long receiver hold-off and a sender drain.",
             matches_cnt);
    if (mismatch_cnt == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // Watchdog far beyond the slowest legal run
  initial begin
    #5_000_000;
    $display("Mismatches found");
    $finish;
  end

endmodule

`default_nettype wire

// ----- filelist.f -----
src/rhsm_pkg.sv
src/rhsm_ctrl.sv
src/rhsm_datapath.sv
src/rolling_hash_substring_matcher.sv
src/rhsm_checker.sv
sim/rolling_hash_substring_matcher_tb.sv
